// ===== rtl/core/cre_pkg.sv =====
`timescale 1ns / 1ps

package cre_pkg;

  localparam logic [7:0] DASH_CHAR = 8'h2D;
  localparam logic [7:0] NUL_CHAR  = 8'h00;

  // Character classes; a range needs both ends in the same non-zero class.
  localparam logic [1:0] CLASS_NONE   = 2'd0;
  localparam logic [1:0] CLASS_DIGIT  = 2'd1;
  localparam logic [1:0] CLASS_LETTER = 2'd2;

  typedef struct packed {
    logic       emit;
    logic       fin;
    logic [7:0] ch;
    logic       last;
  } gen_t;

  function automatic logic [1:0] byte_class(input logic [7:0] c);
    logic [1:0] k;
    k = CLASS_NONE;
    if (c >= 8'h30 && c <= 8'h39) begin
      k = CLASS_DIGIT;
    end else if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
      k = CLASS_LETTER;
    end
    return k;
  endfunction

endpackage

// ===== rtl/core/cre_in_if.sv =====
`timescale 1ns / 1ps

interface cre_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink (input valid, input in_char, input in_last, output ready);
endinterface

// ===== rtl/core/cre_out_if.sv =====
`timescale 1ns / 1ps

interface cre_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       run_end;
  logic       string_end;

  modport source (output valid, output out_char, output run_end, output string_end,
                  input ready);
  modport sink (input valid, input out_char, input run_end, input string_end,
                output ready);
endinterface

// ===== rtl/core/cre_run.sv =====
`timescale 1ns / 1ps

module cre_run (
  input  logic       clk,
  input  logic       load,
  input  logic [7:0] start,
  input  logic [7:0] stop,
  input  logic       step,
  output logic [7:0] next_char,
  output logic [7:0] stop_char,
  output logic       at_stop
);

  logic [7:0] run_next_char;
  logic [7:0] run_stop_char;

  always_ff @(posedge clk) begin
    if (load) begin
      run_next_char <= start;
      run_stop_char <= stop;
    end else if (step) begin
      run_next_char <= run_next_char + 8'd1;
    end
  end

  assign next_char = run_next_char;
  assign stop_char = run_stop_char;
  assign at_stop   = (run_next_char == run_stop_char);

endmodule

// ===== rtl/core/cre_seq.sv =====
`timescale 1ns / 1ps

module cre_seq (
  input  logic          clk,
  input  logic          rst,
  cre_in_if.sink        in_word,
  output cre_pkg::gen_t gen,
  input  logic          stall
);
  import cre_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_LIT_A, S_LIT_DASH, S_LIT_C, S_RUN, S_DONE
  } state_t;

  state_t     state;
  logic [7:0] w0, w1, w2;
  logic [1:0] cnt;
  logic [1:0] range_end_kind;
  logic       last_r;

  logic [7:0] a, b, c;
  logic [1:0] kind;
  logic       match, chained, more;
  logic       run_load, run_step, at_stop;
  logic [7:0] run_start, run_stop, next_char, stop_char;

  assign a       = w0;
  assign b       = (cnt > 2'd1) ? w1 : NUL_CHAR;
  assign c       = (cnt == 2'd3) ? w2 : NUL_CHAR;
  assign kind    = byte_class(a);
  assign match   = (kind != CLASS_NONE) && (b == DASH_CHAR) && (byte_class(c) == kind);
  assign chained = (range_end_kind == kind);
  assign more    = (cnt == 2'd3) || (last_r && (cnt != 2'd0));

  // The shared unit is loaded by each decision that emits and then stepped per byte of a run.
  always_comb begin
    run_load  = 1'b0;
    run_start = a;
    run_stop  = a;
    if (state == S_DECIDE && more) begin
      if (match) begin
        run_stop = c;
        if (a > c) begin
          run_load = 1'b1;
        end else if (!(chained && a == c)) begin
          run_load  = 1'b1;
          run_start = chained ? a + 8'd1 : a;
        end
      end else if (range_end_kind == CLASS_NONE) begin
        run_load = 1'b1;
      end
    end
  end

  assign run_step = (state == S_RUN) && !stall && !at_stop;

  cre_run u_run (
    .clk       (clk),
    .load      (run_load),
    .start     (run_start),
    .stop      (run_stop),
    .step      (run_step),
    .next_char (next_char),
    .stop_char (stop_char),
    .at_stop   (at_stop)
  );

  always_comb begin
    gen.emit = 1'b0;
    gen.fin  = (state == S_DONE);
    gen.last = last_r;
    gen.ch   = next_char;
    unique case (state)
      S_RUN, S_LIT_A: begin
        gen.emit = 1'b1;
      end
      S_LIT_DASH: begin
        gen.emit = 1'b1;
        gen.ch   = DASH_CHAR;
      end
      S_LIT_C: begin
        gen.emit = 1'b1;
        gen.ch   = stop_char;
      end
      default: begin
      end
    endcase
  end

  assign in_word.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      cnt            <= 2'd0;
      range_end_kind <= CLASS_NONE;
      last_r         <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_word.valid) begin
            unique case (cnt)
              2'd0:    w0 <= in_word.in_char;
              2'd1:    w1 <= in_word.in_char;
              default: w2 <= in_word.in_char;
            endcase
            cnt    <= cnt + 2'd1;
            last_r <= in_word.in_last;
            state  <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (!more) begin
            state <= S_DONE;
          end else if (match) begin
            // A range or literal triple consumes two window places.
            w0             <= c;
            cnt            <= (cnt == 2'd3) ? 2'd1 : 2'd0;
            range_end_kind <= kind;
            if (a > c) begin
              state <= chained ? S_LIT_DASH : S_LIT_A;
            end else if (chained && a == c) begin
              state <= S_DECIDE;
            end else begin
              state <= S_RUN;
            end
          end else begin
            w0             <= b;
            w1             <= c;
            cnt            <= cnt - 2'd1;
            range_end_kind <= CLASS_NONE;
            state          <= (range_end_kind == CLASS_NONE) ? S_RUN : S_DECIDE;
          end
        end
        S_LIT_A: begin
          if (!stall) state <= S_LIT_DASH;
        end
        S_LIT_DASH: begin
          if (!stall) state <= S_LIT_C;
        end
        S_LIT_C: begin
          if (!stall) state <= S_DECIDE;
        end
        S_RUN: begin
          if (!stall && at_stop) state <= S_DECIDE;
        end
        S_DONE: begin
          if (!stall) begin
            state <= S_IDLE;
            if (last_r) begin
              cnt            <= 2'd0;
              range_end_kind <= CLASS_NONE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/cre_out.sv =====
`timescale 1ns / 1ps

module cre_out (
  input  logic          clk,
  input  logic          rst,
  input  cre_pkg::gen_t gen,
  output logic          stall,
  cre_out_if.source     out_word
);
  import cre_pkg::*;

  // One byte is held back so that run_end can be set on the final word of a step.
  logic       pend_valid;
  logic [7:0] pend_char;
  logic       out_valid;
  logic [7:0] out_char;
  logic       run_end;
  logic       string_end;
  logic       can_move, move;

  assign can_move = !out_valid || out_word.ready;
  assign stall    = pend_valid && !can_move;
  assign move     = (gen.emit || gen.fin) && pend_valid && can_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (move) begin
        out_valid  <= 1'b1;
        out_char   <= pend_char;
        run_end    <= gen.fin;
        string_end <= gen.fin && gen.last;
      end else if (out_word.ready) begin
        out_valid <= 1'b0;
      end
      if (gen.emit && !stall) begin
        pend_valid <= 1'b1;
        pend_char  <= gen.ch;
      end else if (gen.fin && !stall) begin
        pend_valid <= 1'b0;
      end
    end
  end

  assign out_word.valid      = out_valid;
  assign out_word.out_char   = out_char;
  assign out_word.run_end    = run_end;
  assign out_word.string_end = string_end;

endmodule

// ===== rtl/core/char_range_expander.sv =====
`timescale 1ns / 1ps

// Each accepted input word enters the window; each decision then emits its bytes, a run's
// bytes stepped out of the shared run unit, and output stalls hold the sequencer.
// Input is held off while the sequencer works, so a new word is not taken before the last
// one is through. Synchronous active-high reset returns to an empty window.
module char_range_expander (
  input  logic      clk,
  input  logic      rst,
  cre_in_if.sink    in_word,
  cre_out_if.source out_word
);
  import cre_pkg::*;

  gen_t gen;
  logic stall;

  cre_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .in_word (in_word),
    .gen     (gen),
    .stall   (stall)
  );

  cre_out u_out (
    .clk      (clk),
    .rst      (rst),
    .gen      (gen),
    .stall    (stall),
    .out_word (out_word)
  );

endmodule

// ===== rtl/core/cre_check.sv =====
`timescale 1ns / 1ps

module cre_check (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       run_end,
  input logic       string_end
);

  // The block works on one word at a time, so it is busy right after taking one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready straight after an accepted word");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(run_end)
      && $stable(string_end))
    else $error("stalled output word changed");

  a_string_end_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && string_end |-> run_end)
    else $error("string end without run end");

  // A word on offer always carries fully defined fields.
  a_out_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !$isunknown({out_char, run_end, string_end}))
    else $error("output word with unknown fields");

endmodule

bind char_range_expander cre_check u_cre_check (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_word.valid),
  .in_ready   (in_word.ready),
  .out_valid  (out_word.valid),
  .out_ready  (out_word.ready),
  .out_char   (out_word.out_char),
  .run_end    (out_word.run_end),
  .string_end (out_word.string_end)
);

// ===== tb/char_range_expander_test.sv =====
`timescale 1ns / 1ps

module char_range_expander_test;
  import cre_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;
  localparam int MAX_WORDS   = 60;
  localparam int PHASE_WORDS = 50;

  typedef struct packed {
    logic [7:0] ch;
    logic       run_end;
    logic       string_end;
  } exp_word_t;

  class expansion_scoreboard;
    logic [7:0] held0, held1;
    int         held_n;
    logic [1:0] end_kind;
    logic [7:0] step_bytes[$];
    exp_word_t  predicted_q[$];
    int         fail_count;
    int         checked;
    int         strings_done;

    static function logic [1:0] kind_of(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return CLASS_DIGIT;
      if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) return CLASS_LETTER;
      return CLASS_NONE;
    endfunction

    function void push_out(logic [7:0] c);
      if (step_bytes.size() < MAX_WORDS) step_bytes.push_back(c);
    endfunction

    // Settles the oldest window position and returns how many bytes it used up.
    function int resolve_head(logic [7:0] a, logic [7:0] b, logic [7:0] c);
      logic [1:0] k;
      logic       chained;
      int         start;
      k = kind_of(a);
      if (k != CLASS_NONE && b == DASH_CHAR && kind_of(c) == k) begin
        chained = (end_kind == k);
        if (a > c) begin
          if (!chained) push_out(a);
          push_out(DASH_CHAR);
          push_out(c);
        end else begin
          start = chained ? int'(a) + 1 : int'(a);
          for (int v = start; v <= int'(c); v++) push_out(8'(v));
        end
        end_kind = k;
        return 2;
      end
      if (end_kind == CLASS_NONE) push_out(a);
      end_kind = CLASS_NONE;
      return 1;
    endfunction

    function void note_input(logic [7:0] ch, logic last);
      logic [7:0] win[3];
      logic [7:0] b, c;
      int         fill, used;
      exp_word_t  w;
      step_bytes.delete();
      fill = held_n;
      win[0] = held0;
      win[1] = held1;
      win[2] = NUL_CHAR;
      win[fill] = ch;
      fill++;
      while (fill == 3 || (last && fill > 0)) begin
        b = (fill > 1) ? win[1] : NUL_CHAR;
        c = (fill > 2) ? win[2] : NUL_CHAR;
        used = resolve_head(win[0], b, c);
        if (used == 2) begin
          win[0] = win[2];
          win[1] = NUL_CHAR;
          win[2] = NUL_CHAR;
          fill = (fill > 2) ? fill - 2 : 0;
        end else begin
          win[0] = win[1];
          win[1] = win[2];
          win[2] = NUL_CHAR;
          fill--;
        end
      end
      if (last) begin
        held0 = NUL_CHAR;
        held1 = NUL_CHAR;
        held_n = 0;
        end_kind = CLASS_NONE;
        strings_done++;
      end else begin
        held0 = win[0];
        held1 = win[1];
        held_n = fill;
      end
      foreach (step_bytes[i]) begin
        w.ch = step_bytes[i];
        w.run_end = (i == step_bytes.size() - 1);
        w.string_end = last && (i == step_bytes.size() - 1);
        predicted_q.push_back(w);
      end
    endfunction

    function void check_result(logic [7:0] ch, logic re, logic se);
      exp_word_t w;
      if (predicted_q.size() == 0) begin
        $error("unexpected output word: out_char %02h", ch);
        fail_count++;
        return;
      end
      w = predicted_q.pop_front();
      checked++;
      if (ch !== w.ch) begin
        $error("out_char: expected %02h, actual %02h", w.ch, ch);
        fail_count++;
      end
      if (re !== w.run_end) begin
        $error("run_end: expected %0b, actual %0b", w.run_end, re);
        fail_count++;
      end
      if (se !== w.string_end) begin
        $error("string_end: expected %0b, actual %0b", w.string_end, se);
        fail_count++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   send_idle_pct = 35;
  int   recv_idle_pct = 73;
  int   words_sent;
  int   stall_cycles;

  expansion_scoreboard sb = new();

  cre_in_if  in_word();
  cre_out_if out_word();

  char_range_expander u_top (
    .clk      (clk),
    .rst      (rst),
    .in_word  (in_word),
    .out_word (out_word)
  );

  always #5 clk = ~clk;

  initial begin
    in_word.valid = 1'b0;
    in_word.in_char = 8'h00;
    in_word.in_last = 1'b0;
    out_word.ready = 1'b0;
  end

  always @(negedge clk) begin
    out_word.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_word.valid && in_word.ready) begin
        sb.note_input(in_word.in_char, in_word.in_last);
      end
      if (out_word.valid && out_word.ready) begin
        sb.check_result(out_word.out_char, out_word.run_end, out_word.string_end);
      end
      if ((in_word.valid && in_word.ready) || (out_word.valid && out_word.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("char_range_expander_test: FAIL");
    $finish;
  end

  task automatic send_word(input logic [7:0] ch, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_word.valid = 1'b0;
      @(negedge clk);
    end
    in_word.valid = 1'b1;
    in_word.in_char = ch;
    in_word.in_last = last;
    @(posedge clk);
    while (!in_word.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_bytes(input logic [7:0] s[$]);
    foreach (s[i]) send_word(s[i], i == s.size() - 1);
  endtask

  task automatic send_text(input string t);
    logic [7:0] s[$];
    for (int i = 0; i < t.len(); i++) s.push_back(t[i]);
    send_bytes(s);
  endtask

  // Holds the input off until every predicted word has come out.
  task automatic drain;
    @(negedge clk);
    in_word.valid = 1'b0;
    while (sb.predicted_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_char(logic [1:0] k);
    int idx;
    if (k == CLASS_DIGIT) return 8'(8'h30 + $urandom_range(9));
    idx = $urandom_range(51);
    return (idx < 26) ? 8'(8'h41 + idx) : 8'(8'h61 + idx - 26);
  endfunction

  // Mostly well-formed ranges and chains, mixed with stray bytes and broken triples.
  function automatic void build_string(ref logic [7:0] s[$]);
    logic [1:0] k;
    logic [7:0] lo, hi, t;
    s.delete();
    repeat ($urandom_range(1, 4)) begin
      k = $urandom_range(1) ? CLASS_LETTER : CLASS_DIGIT;
      lo = pick_char(k);
      hi = pick_char(k);
      if (lo > hi && $urandom_range(3) != 0) begin
        t = lo;
        lo = hi;
        hi = t;
      end
      case ($urandom_range(9))
        0, 1, 2, 3, 4: begin
          if (s.size() > 0 && expansion_scoreboard::kind_of(s[$]) == k && $urandom_range(1)) begin
            s.push_back(DASH_CHAR);
            s.push_back(hi);
          end else begin
            s.push_back(lo);
            s.push_back(DASH_CHAR);
            s.push_back(hi);
          end
        end
        5, 6: s.push_back(8'($urandom_range(1, 255)));
        7: s.push_back(DASH_CHAR);
        8: s.push_back(lo);
        default: begin
          s.push_back(lo);
          s.push_back(DASH_CHAR);
          s.push_back(pick_char(k == CLASS_DIGIT ? CLASS_LETTER : CLASS_DIGIT));
        end
      endcase
    end
  endfunction

  initial begin
    logic [7:0] s[$];
    int         phase_start;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_text("0-9");
    send_text("A-z");
    send_text("1-2-3");
    send_text("7-9-5");
    send_text("1-1-1");
    s = '{8'hFF, 8'h00, DASH_CHAR, 8'h01};
    send_bytes(s);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 73 : 0;
      recv_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 35 : 0;
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS) begin
        build_string(s);
        send_bytes(s);
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d words in %0d strings: digit and letter ranges, chains, descending",
             words_sent, sb.strings_done);
    $display("and empty-tail cases under three stall mixes; %0d expanded words checked.",
             sb.checked);
    if (sb.fail_count == 0 && sb.predicted_q.size() == 0) begin
      $display("char_range_expander_test: PASS");
    end else begin
      $display("char_range_expander_test: FAIL");
    end
    $finish;
  end

endmodule
